// ===== rtl/dsfa_pkg.sv =====
// Shared constants, codes and types for the deferred free slot allocator.
`default_nettype none
package dsfa_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W      = 16;
    localparam int TIME_W     = 64;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int PEND_W     = SLOT_W + TIME_W;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COLLECT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC_RD,
        ST_FREE_RD,
        ST_COLLECT
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/dsfa_if.sv =====
// Request and response channel interfaces of the slot allocator.
`default_nettype none
interface dsfa_req_if;
    logic                         valid;
    logic                         ready;
    logic [dsfa_pkg::REQ_W-1:0]   req_type;
    logic [dsfa_pkg::IDX_W-1:0]   slot_index;
    logic [dsfa_pkg::TIME_W-1:0]  timeline_value;

    modport source (output valid, output req_type, output slot_index,
                    output timeline_value, input ready);
    modport sink   (input valid, input req_type, input slot_index,
                    input timeline_value, output ready);
endinterface

interface dsfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dsfa_pkg::STATUS_W-1:0] status;
    logic [dsfa_pkg::SLOT_W-1:0]   slot_out;
    logic [dsfa_pkg::CNT_W-1:0]    reclaimed;

    modport source (output valid, output status, output slot_out,
                    output reclaimed, input ready);
    modport sink   (input valid, input status, input slot_out,
                    input reclaimed, output ready);
endinterface
`default_nettype wire

// ===== rtl/deferred_free_slot_allocator_unit.sv =====
// Top level of the deferred free slot allocator: control sequencer and state memories.
// Sequence: allocate from the high-water mark, full, out-of-range free and empty collect
//   answer straight from ST_IDLE; allocate from the free stack passes through ST_ALLOC_RD and
//   free through ST_FREE_RD; collect walks the pending list, one pending entry per cycle.
// Throughput: one request at a time; the next request is taken the cycle after the
//   result is registered, as long as the response register is empty or draining.
// Reset: rst_n clears counts and control at once; memories need no clearing.
`default_nettype none
module deferred_free_slot_allocator_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    dsfa_req_if.sink  req,
    dsfa_rsp_if.source rsp
);
    import dsfa_pkg::*;

    localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    state_t state_reg, state_next;

    // Counts and walk pointers
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  recl_reg, recl_next;

    // Request payload held across the multi-cycle operations
    logic [TIME_W-1:0] tv_reg, tv_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;

    // Response register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    recl_out_reg, recl_out_next;

    // Memory ports
    logic              fs_we, fs_re;
    logic [SLOT_W-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rdata;
    logic              live_we, live_re, live_wdata, live_rdata;
    logic [SLOT_W-1:0] live_waddr, live_raddr;
    logic              pd_we, pd_re;
    logic [SLOT_W-1:0] pd_waddr, pd_raddr;
    logic [PEND_W-1:0] pd_wdata, pd_rdata;

    logic              accept;
    logic [CNT_W-1:0]  fc_dec;
    logic [SLOT_W-1:0] pd_slot;
    logic [TIME_W-1:0] pd_retire;

    // Free stack: reclaimed slots, bottom first
    dsfa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_free_stack (
        .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .re(fs_re), .raddr(fs_raddr), .rdata(fs_rdata)
    );

    // Live bits: only read below the high-water mark, where every entry was written
    dsfa_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_live (
        .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
        .re(live_re), .raddr(live_raddr), .rdata(live_rdata)
    );

    // Pending list: {slot, retire time} in free order
    dsfa_ram #(.WIDTH(PEND_W), .DEPTH(SLOT_COUNT)) u_pending (
        .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
        .re(pd_re), .raddr(pd_raddr), .rdata(pd_rdata)
    );

    assign req.ready     = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.slot_out  = slot_reg;
    assign rsp.reclaimed = recl_out_reg;

    assign fc_dec    = free_cnt_reg - CNT_W'(1);
    assign pd_slot   = pd_rdata[PEND_W-1:TIME_W];
    assign pd_retire = pd_rdata[TIME_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        free_cnt_next  = free_cnt_reg;
        hw_next        = hw_reg;
        pend_cnt_next  = pend_cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        kept_next      = kept_reg;
        recl_next      = recl_reg;
        tv_next        = tv_reg;
        idx_next       = idx_reg;
        // Drop the response once the sink takes it
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        recl_out_next  = recl_out_reg;

        fs_we      = 1'b0;
        fs_waddr   = free_cnt_reg[SLOT_W-1:0];
        fs_wdata   = pd_slot;
        fs_re      = 1'b0;
        fs_raddr   = fc_dec[SLOT_W-1:0];
        live_we    = 1'b0;
        live_waddr = hw_reg[SLOT_W-1:0];
        live_wdata = 1'b1;
        live_re    = 1'b0;
        live_raddr = req.slot_index[SLOT_W-1:0];
        pd_we      = 1'b0;
        pd_waddr   = kept_reg[SLOT_W-1:0];
        pd_wdata   = pd_rdata;
        pd_re      = 1'b0;
        pd_raddr   = rd_ptr_reg[SLOT_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Default answer: done with zero payload
                    out_valid_next = 1'b1;
                    status_next    = STATUS_DONE;
                    slot_next      = '0;
                    recl_out_next  = '0;
                    case (req.req_type)
                        REQ_ALLOC:
                        begin
                            if (free_cnt_reg != '0)
                            begin
                                // Pop the most recently reclaimed slot
                                out_valid_next = 1'b0;
                                fs_re          = 1'b1;
                                free_cnt_next  = fc_dec;
                                state_next     = ST_ALLOC_RD;
                            end
                            else if (hw_reg < CNT_W'(SLOT_COUNT))
                            begin
                                live_we   = 1'b1;
                                hw_next   = hw_reg + CNT_W'(1);
                                slot_next = hw_reg[SLOT_W-1:0];
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (CMP_W'(req.slot_index) >= CMP_W'(hw_reg))
                            begin
                                status_next = STATUS_IGNORED;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                live_re        = 1'b1;
                                idx_next       = req.slot_index[SLOT_W-1:0];
                                tv_next        = req.timeline_value;
                                state_next     = ST_FREE_RD;
                            end
                        end
                        REQ_COLLECT:
                        begin
                            if (pend_cnt_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                pd_re          = 1'b1;
                                pd_raddr       = '0;
                                rd_ptr_next    = CNT_W'(1);
                                kept_next      = '0;
                                recl_next      = '0;
                                tv_next        = req.timeline_value;
                                state_next     = ST_COLLECT;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_DONE;
                        end
                    endcase
                end
            end

            ST_ALLOC_RD:
            begin
                live_we        = 1'b1;
                live_waddr     = fs_rdata;
                out_valid_next = 1'b1;
                status_next    = STATUS_DONE;
                slot_next      = fs_rdata;
                recl_out_next  = '0;
                state_next     = ST_IDLE;
            end

            ST_FREE_RD:
            begin
                out_valid_next = 1'b1;
                slot_next      = '0;
                recl_out_next  = '0;
                if (live_rdata && (pend_cnt_reg < CNT_W'(SLOT_COUNT)))
                begin
                    // Retire the slot onto the end of the pending list
                    live_we       = 1'b1;
                    live_waddr    = idx_reg;
                    live_wdata    = 1'b0;
                    pd_we         = 1'b1;
                    pd_waddr      = pend_cnt_reg[SLOT_W-1:0];
                    pd_wdata      = {idx_reg, tv_reg};
                    pend_cnt_next = pend_cnt_reg + CNT_W'(1);
                    status_next   = STATUS_DONE;
                end
                else
                begin
                    status_next = STATUS_IGNORED;
                end
                state_next = ST_IDLE;
            end

            ST_COLLECT:
            begin
                // Entry rd_ptr_reg - 1 is on the read port
                if (pd_retire <= tv_reg)
                begin
                    if (free_cnt_reg < CNT_W'(SLOT_COUNT))
                    begin
                        fs_we         = 1'b1;
                        free_cnt_next = free_cnt_reg + CNT_W'(1);
                    end
                    recl_next = recl_reg + CNT_W'(1);
                end
                else
                begin
                    // Compact the survivor; kept never passes the read pointer
                    pd_we     = 1'b1;
                    kept_next = kept_reg + CNT_W'(1);
                end
                if (rd_ptr_reg < pend_cnt_reg)
                begin
                    pd_re       = 1'b1;
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_cnt_next  = kept_next;
                    out_valid_next = 1'b1;
                    status_next    = STATUS_DONE;
                    slot_next      = '0;
                    recl_out_next  = recl_next;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_cnt_reg  <= '0;
            hw_reg        <= '0;
            pend_cnt_reg  <= '0;
            rd_ptr_reg    <= '0;
            kept_reg      <= '0;
            recl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_cnt_reg  <= free_cnt_next;
            hw_reg        <= hw_next;
            pend_cnt_reg  <= pend_cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            kept_reg      <= kept_next;
            recl_reg      <= recl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        tv_reg       <= tv_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        recl_out_reg <= recl_out_next;
    end

endmodule
`default_nettype wire

// ===== rtl/dsfa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module dsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dsfa_checker.sv =====
// Port-level assertions for the slot allocator and their bind to the top level.
`default_nettype none
module dsfa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [dsfa_pkg::STATUS_W-1:0] status,
    input wire logic [dsfa_pkg::SLOT_W-1:0]   slot_out,
    input wire logic [dsfa_pkg::CNT_W-1:0]    reclaimed
);
    import dsfa_pkg::*;

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_DONE || status == STATUS_FULL ||
                       status == STATUS_IGNORED))
        else $error("unused status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_DONE |-> slot_out == '0 && reclaimed == '0)
        else $error("failed request carries a payload");

    a_recl_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && reclaimed != '0 |-> slot_out == '0)
        else $error("collect result carries a slot");

endmodule

bind deferred_free_slot_allocator_unit dsfa_checker u_dsfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .slot_out  (rsp.slot_out),
    .reclaimed (rsp.reclaimed)
);
`default_nettype wire

// ===== tb/deferred_free_slot_allocator_unit_tb.sv =====
// Self-checking testbench for the deferred free slot allocator unit.
module deferred_free_slot_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsfa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [CNT_W-1:0]    reclaimed;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dsfa_req_if req ();
    dsfa_rsp_if rsp ();

    deferred_free_slot_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    logic [SLOT_W-1:0] free_stack_sh [SLOT_COUNT];
    int                free_depth;
    int                fresh_mark;
    bit                live_sh [SLOT_COUNT];
    logic [SLOT_W-1:0] pend_slot_sh [SLOT_COUNT];
    logic [63:0]       pend_time_sh [SLOT_COUNT];
    int                pend_depth;

    answer_t answers_due [$];
    int      fail_count = 0;
    int      answers_seen = 0;
    int      sent_count = 0;
    int      cycle_count = 0;
    int      op_count [4] = '{0, 0, 0, 0};
    int      full_hits = 0;
    int      ignored_hits = 0;
    bit      hold_off = 1'b0;
    int      hold_cycles = 0;

    // Compute the answer of one request and advance the shadow state.
    function automatic answer_t allocator_answer(logic [REQ_W-1:0] kind,
                                                 logic [IDX_W-1:0] idx,
                                                 logic [63:0] tv);
        answer_t a;
        int kept;
        a = '0;
        a.status = STATUS_DONE;
        if (kind == REQ_ALLOC)
        begin
            if (free_depth > 0)
            begin
                free_depth--;
                a.slot_out = free_stack_sh[free_depth];
                live_sh[a.slot_out] = 1'b1;
            end
            else if (fresh_mark < SLOT_COUNT)
            begin
                a.slot_out = fresh_mark[SLOT_W-1:0];
                live_sh[fresh_mark] = 1'b1;
                fresh_mark++;
            end
            else
                a.status = STATUS_FULL;
        end
        else if (kind == REQ_FREE)
        begin
            if (idx >= fresh_mark || idx >= SLOT_COUNT || !live_sh[idx] ||
                pend_depth >= SLOT_COUNT)
                a.status = STATUS_IGNORED;
            else
            begin
                live_sh[idx] = 1'b0;
                pend_slot_sh[pend_depth] = idx[SLOT_W-1:0];
                pend_time_sh[pend_depth] = tv;
                pend_depth++;
            end
        end
        else if (kind == REQ_COLLECT)
        begin
            kept = 0;
            for (int i = 0; i < pend_depth; i++)
            begin
                if (pend_time_sh[i] <= tv)
                begin
                    if (free_depth < SLOT_COUNT)
                    begin
                        free_stack_sh[free_depth] = pend_slot_sh[i];
                        free_depth++;
                    end
                    a.reclaimed++;
                end
                else
                begin
                    pend_slot_sh[kept] = pend_slot_sh[i];
                    pend_time_sh[kept] = pend_time_sh[i];
                    kept++;
                end
            end
            pend_depth = kept;
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (answer %0d)",
                 what, got, want, answers_seen);
        fail_count++;
    endtask

    // Offer one request after a random gap; hold until the transfer happens.
    task automatic send_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                logic [63:0] tv);
        answer_t a;
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // Lower valid only for a real gap; back to back requests keep it high.
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.req_type       <= kind;
        req.slot_index     <= idx;
        req.timeline_value <= tv;
        do
            @(posedge clk);
        while (!req.ready);
        a = allocator_answer(kind, idx, tv);
        answers_due = {answers_due, a};
        sent_count++;
        op_count[kind]++;
        if (a.status == STATUS_FULL)
            full_hits++;
        if (a.status == STATUS_IGNORED)
            ignored_hits++;
    endtask

    // Pick a slot that is currently live, or any slot when none is.
    function automatic logic [IDX_W-1:0] pick_live();
        int start;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++)
            if (live_sh[(start + k) % SLOT_COUNT])
                return IDX_W'((start + k) % SLOT_COUNT);
        return IDX_W'($urandom_range(0, SLOT_COUNT - 1));
    endfunction

    function automatic logic [63:0] rand_time();
        return {$urandom(), $urandom()};
    endfunction

    // Drop valid, wait until every expected answer has arrived, then a short settle.
    task automatic drain();
        req.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: stall at random, check each transfer against the oldest answer.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            while (stall > 0 || hold_off)
            begin
                rsp.ready <= 1'b0;
                @(posedge clk);
                if (stall > 0)
                    stall--;
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            // Transfer happens at this edge: valid and ready both high.
            if (answers_due.size() == 0)
            begin
                report_mismatch("unexpected answer, status", rsp.status, 0);
            end
            else
            begin
                answer_t w;
                w = answers_due.pop_front();
                if (rsp.status !== w.status)
                    report_mismatch("status", rsp.status, w.status);
                if (rsp.slot_out !== w.slot_out)
                    report_mismatch("slot_out", rsp.slot_out, w.slot_out);
                if (rsp.reclaimed !== w.reclaimed)
                    report_mismatch("reclaimed", rsp.reclaimed, w.reclaimed);
            end
            answers_seen++;
        end
    end

    // Long receiver hold-off, counted here in cycles.
    initial
    begin
        wait (hold_off);
        while (hold_cycles < 300)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Field extremes, every request code and the unused one.
    task automatic test_directed();
        send_request(REQ_FREE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_FREE, 16'h0000, 64'h0);
        send_request(REQ_COLLECT, 16'hFFFF, 64'h0);
        send_request(REQ_ALLOC, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        send_request(REQ_FREE, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_FREE, 16'd1, 64'h5);
        send_request(REQ_FREE, 16'd0, 64'h0);
        send_request(REQ_FREE, 16'd3, 64'h0);
        send_request(REQ_COLLECT, 16'h0, 64'h0);
        send_request(REQ_COLLECT, 16'h0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_request(REQ_COLLECT, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        send_request(2'd3, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(2'd3, 16'h0, 64'h0);
        send_request(REQ_FREE, 16'h0400, 64'h1);
        drain();
    endtask

    // Exhaust the slot space to reach the full answer, then retire a handful
    // of slots with spread retire times and reclaim them in two collects.
    task automatic test_exhaust();
        int freed;
        freed = 0;
        while (fresh_mark < SLOT_COUNT || free_depth > 0)
            send_request(REQ_ALLOC, IDX_W'($urandom()), rand_time());
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        for (int s = 0; s < SLOT_COUNT && freed < 16; s++)
            if (live_sh[s])
            begin
                send_request(REQ_FREE, IDX_W'(s), 64'(freed * 100));
                freed++;
            end
        send_request(REQ_FREE, 16'd5, 64'h0);
        send_request(REQ_COLLECT, 16'h0, 64'd800);
        send_request(REQ_COLLECT, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        send_request(REQ_ALLOC, 16'h0, 64'h0);
        drain();
    endtask

    // Receiver holds off while requests keep coming, so the block stalls.
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 20; n++)
            send_request(REQ_ALLOC, 16'h0, 64'h0);
        drain();
    endtask

    // Mostly well-formed alloc/free/collect traffic with random content.
    task automatic test_random(int count);
        int pick;
        logic [63:0] base;
        logic [IDX_W-1:0] idx;
        base = 64'd1000;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_request(REQ_ALLOC, IDX_W'($urandom()), rand_time());
            else if (pick < 75)
                send_request(REQ_FREE, pick_live(), base + $urandom_range(0, 200));
            else if (pick < 85)
            begin
                base += $urandom_range(0, 100);
                send_request(REQ_COLLECT, IDX_W'($urandom()),
                             base + $urandom_range(0, 100));
            end
            else if (pick < 93)
            begin
                // Bad free: random slot, often out of range or not live.
                idx = IDX_W'($urandom());
                send_request(REQ_FREE, idx, rand_time());
            end
            else if (pick < 97)
                send_request(REQ_COLLECT, IDX_W'($urandom()), rand_time());
            else
                send_request(2'd3, IDX_W'($urandom()), rand_time());
        end
        drain();
    endtask

    initial
    begin
        req.valid          = 1'b0;
        req.req_type       = REQ_ALLOC;
        req.slot_index     = '0;
        req.timeline_value = '0;
        free_depth = 0;
        fresh_mark = 0;
        pend_depth = 0;
        foreach (live_sh[i])
            live_sh[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_exhaust();
        test_random(60);

        repeat (20) @(posedge clk);
        $display("Covered %0d requests: %0d alloc, %0d free, %0d collect, %0d unused code",
                 sent_count, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Full answers %0d, ignored frees %0d, receiver hold %0d cycles",
                 full_hits, ignored_hits, hold_cycles);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
